// ===== rtl/core/assert_macros.svh =====
// Shared assertion forms for the lexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/plx_pkg.sv =====
package plx_pkg;

    localparam logic [1:0] RK_TOKEN = 2'd0;
    localparam logic [1:0] RK_SBYTE = 2'd1;
    localparam logic [1:0] RK_DIAG  = 2'd2;

    localparam logic [1:0] DG_NONE    = 2'd0;
    localparam logic [1:0] DG_ILLEGAL = 2'd1;
    localparam logic [1:0] DG_UNTERM  = 2'd2;
    localparam logic [1:0] DG_ESCAPE  = 2'd3;

    localparam logic [4:0] TK_IDENT       = 5'd9;
    localparam logic [4:0] TK_INT         = 5'd10;
    localparam logic [4:0] TK_STRING      = 5'd11;
    localparam logic [4:0] TK_LPAREN      = 5'd12;
    localparam logic [4:0] TK_RPAREN      = 5'd13;
    localparam logic [4:0] TK_LBRACE      = 5'd14;
    localparam logic [4:0] TK_RBRACE      = 5'd15;
    localparam logic [4:0] TK_DOT         = 5'd16;
    localparam logic [4:0] TK_COMMA       = 5'd17;
    localparam logic [4:0] TK_SEMI        = 5'd18;
    localparam logic [4:0] TK_PLUS        = 5'd19;
    localparam logic [4:0] TK_MINUS       = 5'd20;
    localparam logic [4:0] TK_STAR        = 5'd21;
    localparam logic [4:0] TK_SLASH       = 5'd22;
    localparam logic [4:0] TK_COLON       = 5'd23;
    localparam logic [4:0] TK_COLON_EQUAL = 5'd24;
    localparam logic [4:0] TK_EOF         = 5'd25;

    localparam int NUM_KW = 9;

    localparam logic [7:0] KW_TEXT [NUM_KW][9] = '{
        '{"p", "r", "o", "g", "r", "a", "m", 8'h00, 8'h00},
        '{"p", "r", "o", "c", "e", "d", "u", "r", "e"},
        '{"b", "e", "g", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "h", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd7, 4'd9, 4'd5, 4'd3, 4'd3, 4'd5, 4'd2, 4'd4, 4'd4
    };

    typedef struct packed {
        logic        last;
        logic [1:0]  diag;
        logic [7:0]  sbyte;
        logic [23:0] len;
        logic [23:0] start;
        logic [4:0]  tk;
        logic [1:0]  kind;
    } t_result;

    function automatic logic [NUM_KW-1:0] f_kw_feed(input logic [NUM_KW-1:0] kw,
                                                    input logic [3:0] wlen,
                                                    input logic [7:0] c);
        logic [NUM_KW-1:0] keep;
        for (int k = 0; k < NUM_KW; k++) begin
            keep[k] = kw[k] && (wlen < KW_LEN[k]) && (KW_TEXT[k][wlen] == c);
        end
        return keep;
    endfunction

endpackage

// ===== rtl/core/plx_scan.sv =====
module plx_scan #(
    parameter int POSITION_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic              i_cmd,
    input  logic [7:0]        i_byte,
    output logic [1:0]        o_count,
    output plx_pkg::t_result  o_res0,
    output plx_pkg::t_result  o_res1
);

    localparam int PB  = POSITION_BITS;
    localparam int EXT = (PB + 1 > 24) ? PB + 1 : 24;

    localparam logic [3:0] M_IDLE       = 4'd0;
    localparam logic [3:0] M_IDENT      = 4'd1;
    localparam logic [3:0] M_NUMBER     = 4'd2;
    localparam logic [3:0] M_COLON      = 4'd3;
    localparam logic [3:0] M_SLASH      = 4'd4;
    localparam logic [3:0] M_LINE       = 4'd5;
    localparam logic [3:0] M_BLOCK      = 4'd6;
    localparam logic [3:0] M_BLOCK_STAR = 4'd7;
    localparam logic [3:0] M_STRING     = 4'd8;
    localparam logic [3:0] M_STRING_ESC = 4'd9;

    logic [3:0]    r_mode,  n_mode;
    logic [PB-1:0] r_start, n_start;
    logic [PB-1:0] r_pos,   n_pos;
    logic [8:0]    r_kw,    n_kw;
    logic [3:0]    r_wlen,  n_wlen;

    function automatic logic [23:0] f_pos24(input logic [PB:0] v);
        logic [EXT-1:0] w;
        w = EXT'(v);
        return w[23:0];
    endfunction

    function automatic plx_pkg::t_result f_token(input logic [4:0] tk,
                                                 input logic [23:0] st,
                                                 input logic [23:0] len);
        plx_pkg::t_result r;
        r.kind  = plx_pkg::RK_TOKEN;
        r.tk    = tk;
        r.start = st;
        r.len   = len;
        r.sbyte = 8'd0;
        r.diag  = plx_pkg::DG_NONE;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic plx_pkg::t_result f_sbyte(input logic [23:0] st, input logic [7:0] b);
        plx_pkg::t_result r;
        r.kind  = plx_pkg::RK_SBYTE;
        r.tk    = plx_pkg::TK_STRING;
        r.start = st;
        r.len   = 24'd0;
        r.sbyte = b;
        r.diag  = plx_pkg::DG_NONE;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic plx_pkg::t_result f_diag(input logic [23:0] st, input logic [1:0] d);
        plx_pkg::t_result r;
        r.kind  = plx_pkg::RK_DIAG;
        r.tk    = 5'd0;
        r.start = st;
        r.len   = 24'd0;
        r.sbyte = 8'd0;
        r.diag  = d;
        r.last  = 1'b0;
        return r;
    endfunction

    logic             w_alpha, w_digit;
    logic [23:0]      w_pos24, w_start24;
    logic [4:0]       w_flush_tk;
    plx_pkg::t_result w_flush;
    logic             w_ib_has;
    plx_pkg::t_result w_ib_res;
    logic [3:0]       w_ib_mode;
    logic [8:0]       w_ib_kw;
    logic [3:0]       w_ib_wlen;
    logic [4:0]       w_punct_tk;
    logic             w_punct;

    assign w_alpha   = i_byte inside {["a":"z"], ["A":"Z"], "_"};
    assign w_digit   = i_byte inside {["0":"9"]};
    assign w_pos24   = f_pos24({1'b0, r_pos});
    assign w_start24 = f_pos24({1'b0, r_start});

    always_comb begin
        w_flush_tk = plx_pkg::TK_IDENT;
        case (r_mode)
            M_IDENT: begin
                for (int k = 0; k < plx_pkg::NUM_KW; k++) begin
                    if (r_kw[k] && plx_pkg::KW_LEN[k] == r_wlen) begin
                        w_flush_tk = 5'(k);
                    end
                end
            end
            M_NUMBER: w_flush_tk = plx_pkg::TK_INT;
            M_COLON:  w_flush_tk = plx_pkg::TK_COLON;
            default:  w_flush_tk = plx_pkg::TK_SLASH;
        endcase
        w_flush = f_token(w_flush_tk, w_start24, f_pos24({1'b0, r_pos} - {1'b0, r_start}));
    end

    always_comb begin
        w_punct    = 1'b1;
        w_punct_tk = plx_pkg::TK_LPAREN;
        case (i_byte)
            "(":     w_punct_tk = plx_pkg::TK_LPAREN;
            ")":     w_punct_tk = plx_pkg::TK_RPAREN;
            "{":     w_punct_tk = plx_pkg::TK_LBRACE;
            "}":     w_punct_tk = plx_pkg::TK_RBRACE;
            ".":     w_punct_tk = plx_pkg::TK_DOT;
            ",":     w_punct_tk = plx_pkg::TK_COMMA;
            ";":     w_punct_tk = plx_pkg::TK_SEMI;
            "+":     w_punct_tk = plx_pkg::TK_PLUS;
            "-":     w_punct_tk = plx_pkg::TK_MINUS;
            "*":     w_punct_tk = plx_pkg::TK_STAR;
            default: w_punct    = 1'b0;
        endcase
    end

    always_comb begin
        w_ib_has  = 1'b0;
        w_ib_res  = f_token(w_punct_tk, w_pos24, 24'd1);
        w_ib_mode = M_IDLE;
        w_ib_kw   = r_kw;
        w_ib_wlen = r_wlen;
        if (w_punct) begin
            w_ib_has = 1'b1;
        end else if (i_byte == ":") begin
            w_ib_mode = M_COLON;
        end else if (i_byte == "/") begin
            w_ib_mode = M_SLASH;
        end else if (i_byte == "\"") begin
            w_ib_mode = M_STRING;
        end else if (i_byte inside {" ", 8'h09, 8'h0D, 8'h0A}) begin
            w_ib_mode = M_IDLE;
        end else if (w_alpha) begin
            w_ib_mode = M_IDENT;
            w_ib_kw   = plx_pkg::f_kw_feed(9'h1FF, 4'd0, i_byte);
            w_ib_wlen = 4'd1;
        end else if (w_digit) begin
            w_ib_mode = M_NUMBER;
        end else begin
            w_ib_has = 1'b1;
            w_ib_res = f_diag(w_pos24, plx_pkg::DG_ILLEGAL);
        end
    end

    always_comb begin
        logic take_flush;
        logic take_idle;
        take_flush = 1'b0;
        take_idle  = 1'b0;
        n_mode     = r_mode;
        n_start    = r_start;
        n_kw       = r_kw;
        n_wlen     = r_wlen;
        n_pos      = (r_pos == {PB{1'b1}}) ? r_pos : r_pos + 1'b1;
        o_count    = 2'd0;
        o_res0     = w_flush;
        o_res1     = w_ib_res;
        if (i_cmd) begin
            o_res1 = f_token(plx_pkg::TK_EOF,
                             (r_pos == '0) ? 24'd0 : f_pos24({1'b0, r_pos - 1'b1}), 24'd0);
            if (r_mode inside {M_IDENT, M_NUMBER, M_COLON, M_SLASH}) begin
                o_count = 2'd2;
            end else if (r_mode inside {M_STRING, M_STRING_ESC}) begin
                o_res0  = f_diag(w_start24, plx_pkg::DG_UNTERM);
                o_count = 2'd2;
            end else begin
                o_res0  = o_res1;
                o_count = 2'd1;
            end
            n_mode  = M_IDLE;
            n_start = '0;
            n_pos   = '0;
            n_kw    = 9'h1FF;
            n_wlen  = 4'd0;
        end else begin
            case (r_mode)
                M_IDENT: begin
                    if (w_alpha || w_digit) begin
                        n_kw   = plx_pkg::f_kw_feed(r_kw, r_wlen, i_byte);
                        n_wlen = (r_wlen == 4'd15) ? r_wlen : r_wlen + 4'd1;
                    end else begin
                        take_flush = 1'b1;
                    end
                end
                M_NUMBER: take_flush = !w_digit;
                M_COLON: begin
                    if (i_byte == "=") begin
                        o_res0  = f_token(plx_pkg::TK_COLON_EQUAL, w_start24,
                                          f_pos24({1'b0, r_pos} + 1'b1 - {1'b0, r_start}));
                        o_count = 2'd1;
                        n_mode  = M_IDLE;
                    end else begin
                        take_flush = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (i_byte == "/") begin
                        n_mode = M_LINE;
                    end else if (i_byte == "*") begin
                        n_mode = M_BLOCK;
                    end else begin
                        take_flush = 1'b1;
                    end
                end
                M_LINE: begin
                    if (i_byte == 8'h0A) begin
                        n_mode = M_IDLE;
                    end
                end
                M_BLOCK: begin
                    if (i_byte == "*") begin
                        n_mode = M_BLOCK_STAR;
                    end
                end
                M_BLOCK_STAR: begin
                    if (i_byte == "/") begin
                        n_mode = M_IDLE;
                    end else if (i_byte != "*") begin
                        n_mode = M_BLOCK;
                    end
                end
                M_STRING: begin
                    if (i_byte == "\"") begin
                        o_res0  = f_token(plx_pkg::TK_STRING, w_start24,
                                          f_pos24({1'b0, r_pos} + 1'b1 - {1'b0, r_start}));
                        o_count = 2'd1;
                        n_mode  = M_IDLE;
                    end else if (i_byte == "\\") begin
                        n_mode = M_STRING_ESC;
                    end else begin
                        o_res0  = f_sbyte(w_start24, i_byte);
                        o_count = 2'd1;
                    end
                end
                M_STRING_ESC: begin
                    if (i_byte == "\\" || i_byte == "\"") begin
                        o_res0 = f_sbyte(w_start24, i_byte);
                    end else if (i_byte == "n") begin
                        o_res0 = f_sbyte(w_start24, 8'h0A);
                    end else begin
                        o_res0 = f_diag(w_start24, plx_pkg::DG_ESCAPE);
                    end
                    o_count = 2'd1;
                    n_mode  = M_STRING;
                end
                default: take_idle = 1'b1;
            endcase
            // close the pending token, then rescan this byte from idle
            if (take_flush) begin
                o_res0  = w_flush;
                o_res1  = w_ib_res;
                o_count = w_ib_has ? 2'd2 : 2'd1;
            end
            if (take_idle) begin
                o_res0  = w_ib_res;
                o_count = {1'b0, w_ib_has};
            end
            if (take_flush || take_idle) begin
                n_mode  = w_ib_mode;
                n_start = r_pos;
                n_kw    = w_ib_kw;
                n_wlen  = w_ib_wlen;
            end
        end
        if (o_count == 2'd2) begin
            o_res1.last = 1'b1;
        end else begin
            o_res0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_start <= '0;
            r_pos   <= '0;
            r_kw    <= 9'h1FF;
            r_wlen  <= 4'd0;
        end else if (i_go) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_kw    <= n_kw;
            r_wlen  <= n_wlen;
        end
    end

endmodule

// ===== rtl/core/pascal_subset_lexer_top.sv =====
// Channel  Dir  Handshake                      Payload
// input    in   s_axis_tvalid / s_axis_tready  tdata: source byte; tuser: end-of-input
// output   out  m_axis_tvalid / m_axis_tready  tdata: token fields; tuser: result kind;
//                                              tlast: last result of one request
//
// One request a cycle while s_axis_tready is high; it waits in the input register, then the
// scan logic writes its zero, one or two results into a four-entry result queue.
// The queue drains one result a cycle while m_axis_tready is high.
// Synchronous reset clears the scan state, input valid flag, queue pointers and count.
// s_axis_tready drops while a request is held and the queue has fewer than two free
// entries, so the input waits for two free entries whatever results a request gives.
`include "assert_macros.svh"

module pascal_subset_lexer_top #(
    parameter int POSITION_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] token_kind, [28:5] start_position, [52:29] token_length,
    // [60:53] string_byte, [62:61] diagnostic, [63] zero
    output logic [63:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
    output logic        m_axis_tlast
);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    logic             r_in_valid, n_in_valid;
    logic             r_in_cmd;
    logic [7:0]       r_in_byte;
    logic             w_in_acc;
    logic             w_go;
    logic             w_pop;
    logic [1:0]       w_n;
    logic [1:0]       w_push;
    plx_pkg::t_result w_res0, w_res1, w_head;

    plx_pkg::t_result r_q [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_count, n_count;

    assign w_go          = r_in_valid && (r_count <= (QAW+1)'(QDEPTH - 2));
    assign s_axis_tready = !r_in_valid || w_go;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign n_in_valid    = w_in_acc ? 1'b1 : (w_go ? 1'b0 : r_in_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    plx_scan #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_cmd   (r_in_cmd),
        .i_byte  (r_in_byte),
        .o_count (w_n),
        .o_res0  (w_res0),
        .o_res1  (w_res1)
    );

    assign w_push  = w_go ? w_n : 2'd0;
    assign w_pop   = m_axis_tvalid && m_axis_tready;
    assign n_count = r_count + (QAW+1)'(w_push) - (QAW+1)'(w_pop);

    always_ff @(posedge i_clk) begin
        if (w_push != 2'd0) begin
            r_q[r_wr] <= w_res0;
        end
        if (w_push == 2'd2) begin
            r_q[r_wr + 1'b1] <= w_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QAW'(w_push);
            r_rd    <= r_rd + QAW'(w_pop);
            r_count <= n_count;
        end
    end

    assign w_head        = r_q[r_rd];
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {1'b0, w_head.diag, w_head.sbyte, w_head.len,
                            w_head.start, w_head.tk};
    assign m_axis_tuser  = w_head.kind;
    assign m_axis_tlast  = w_head.last;

    `ASSERT_RST(a_queue_bound, i_clk, i_rst_n, r_count <= (QAW+1)'(QDEPTH), "result queue overflow")
    `ASSERT_RST(a_last_order, i_clk, i_rst_n, (w_go && w_n == 2'd2) |-> (!w_res0.last && w_res1.last), "tlast on wrong result")
    `ASSERT_RST(a_eof_emits, i_clk, i_rst_n, (w_go && r_in_cmd) |-> (w_n != 2'd0), "end of input gave no result")
    `ASSERT_RST(a_drain_step, i_clk, i_rst_n, (!w_go && w_pop) |=> (r_count == $past(r_count) - 1'b1), "queue count lost a pop")

endmodule
